/* sv/rgb_pack_palette_match_assert.svh */
// ----------------------------------------------------------------------------
// rgb_pack_palette_match assertion macros
// Assertion helpers shared by the pixel packer modules; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef RGB_PACK_PALETTE_MATCH_ASSERT_SVH
`define RGB_PACK_PALETTE_MATCH_ASSERT_SVH
`ifndef SYNTH
// Property that must hold on every clock edge outside reset.
`define RGBPM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true outside reset.
`define RGBPM_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RGBPM_ASSERT(label, clk, rst_n, prop, msg)
`define RGBPM_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* sv/rgbpm_pkg.sv */
// ----------------------------------------------------------------------------
// rgbpm_pkg
// Shared types, codes and constants of the RGB pixel packer.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbpm_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int FMT_W = 3;
    localparam int DIST_W = 18;
    localparam int BEST_W = 14;

    // Pixel format codes.
    localparam logic [FMT_W-1:0] FMT_332   = 3'd0;
    localparam logic [FMT_W-1:0] FMT_INDEX = 3'd1;
    localparam logic [FMT_W-1:0] FMT_555   = 3'd2;
    localparam logic [FMT_W-1:0] FMT_565   = 3'd3;
    localparam logic [FMT_W-1:0] FMT_888   = 3'd4;
    localparam logic [FMT_W-1:0] FMT_RESET = FMT_888;

    // Item function codes.
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_CONVERT = 1'b1;

    // A palette entry must come strictly closer than this to be chosen.
    localparam logic [BEST_W-1:0] NO_MATCH_LIMIT = 14'd12288;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic load_we;
        logic pack;
        logic search_init;
        logic issue;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_index;
        logic addr_last;
        logic pipe_busy;
    } dp_status_t;

endpackage

`default_nettype wire

/* sv/rgbpm_ram.sv */
// ----------------------------------------------------------------------------
// rgbpm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbpm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/rgbpm_ctrl.sv */
// ----------------------------------------------------------------------------
// rgbpm_ctrl
// Controller: accepts items and sequences the palette scan.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb_pack_palette_match_assert.svh"

module rgbpm_ctrl
    import rgbpm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       func,
    input  dp_status_t      status,
    output logic            busy,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.load_we     = accept && (func == FUNC_LOAD);
        cmd.pack        = accept && (func == FUNC_CONVERT) && !status.is_index;
        cmd.search_init = accept && (func == FUNC_CONVERT) && status.is_index;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.search_init)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.addr_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // The last compare has landed once the pipeline is empty.
                if (!status.pipe_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `RGBPM_ASSERT(a_scan_ends, clk, rst_n, (state_reg == ST_SCAN && status.addr_last) |=> (state_reg == ST_DRAIN), "scan did not end after entry zero")
    `RGBPM_NEVER(a_idle_pipe, clk, rst_n, (state_reg == ST_IDLE) && status.pipe_busy, "search pipeline active while idle")
    `RGBPM_NEVER(a_finish_accept, clk, rst_n, cmd.finish && accept, "item accepted while a search finishes")

endmodule

`default_nettype wire

/* sv/rgbpm_dp.sv */
// ----------------------------------------------------------------------------
// rgbpm_dp
// Datapath: format register, palette store, distance pipeline and packing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb_pack_palette_match_assert.svh"

module rgbpm_dp
    import rgbpm_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    input  wire logic             cfg_we,
    input  wire logic [FMT_W-1:0] cfg_data,
    input  wire logic [7:0]       entry_index,
    input  wire logic [7:0]       red_in,
    input  wire logic [7:0]       green_in,
    input  wire logic [7:0]       blue_in,
    output logic                  done,
    output logic [23:0]           pixel_word
);

    localparam logic [8:0]    ENTRIES_W9 = 9'(PALETTE_ENTRIES);
    localparam logic [AW-1:0] ADDR_TOP   = AW'(PALETTE_ENTRIES - 1);

    logic [FMT_W-1:0]           fmt_reg;
    logic [PALETTE_ENTRIES-1:0] valid_reg;
    logic [7:0]                 r_reg, g_reg, b_reg;
    logic [AW-1:0]              addr_reg;
    logic                       s1_vld_reg, s1_hit_reg;
    logic [AW-1:0]              s1_idx_reg;
    logic                       s2_vld_reg;
    logic [AW-1:0]              s2_idx_reg;
    logic [15:0]                sq_r_reg, sq_g_reg, sq_b_reg;
    logic [BEST_W-1:0]          best_reg;
    logic [AW-1:0]              ans_reg;
    logic                       done_reg;
    logic [23:0]                pixel_word_reg;

    logic                       ram_we;
    logic [AW-1:0]              waddr;
    logic [23:0]                rdata;
    logic [23:0]                entry;
    logic [7:0]                 d_r, d_g, d_b;
    logic [DIST_W-1:0]          dist_sum;
    logic [23:0]                packed_word;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    // Writes beyond the configured palette size are dropped.
    assign ram_we = cmd.load_we && ({1'b0, entry_index} < ENTRIES_W9);
    assign waddr  = entry_index[AW-1:0];

    rgbpm_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata ({red_in, green_in, blue_in}),
        .re    (cmd.issue),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= FMT_RESET;
            valid_reg  <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fmt_reg <= cfg_data;
            end
            if (ram_we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            s1_vld_reg <= cmd.issue;
            s2_vld_reg <= s1_vld_reg;
            done_reg   <= cmd.pack || cmd.finish;
        end
    end

    // Stage 0: scan address; stage 1: entry read; stage 2: squares; then compare.
    always_ff @(posedge clk)
    begin
        if (cmd.search_init)
        begin
            r_reg    <= red_in;
            g_reg    <= green_in;
            b_reg    <= blue_in;
            addr_reg <= ADDR_TOP;
        end
        else if (cmd.issue)
        begin
            addr_reg <= addr_reg - AW'(1);
        end

        s1_idx_reg <= addr_reg;
        s1_hit_reg <= valid_reg[addr_reg];

        s2_idx_reg <= s1_idx_reg;
        sq_r_reg   <= {8'd0, d_r} * {8'd0, d_r};
        sq_g_reg   <= {8'd0, d_g} * {8'd0, d_g};
        sq_b_reg   <= {8'd0, d_b} * {8'd0, d_b};

        if (cmd.search_init)
        begin
            best_reg <= NO_MATCH_LIMIT;
            ans_reg  <= '0;
        end
        else if (s2_vld_reg && (dist_sum < DIST_W'(best_reg)))
        begin
            // Strictly less: the scan runs downward, so ties keep the higher index.
            best_reg <= dist_sum[BEST_W-1:0];
            ans_reg  <= s2_idx_reg;
        end

        if (cmd.pack)
        begin
            pixel_word_reg <= packed_word;
        end
        else if (cmd.finish)
        begin
            pixel_word_reg <= 24'(ans_reg);
        end
    end

    // An entry never written since reset reads as black.
    assign entry    = s1_hit_reg ? rdata : 24'd0;
    assign d_r      = abs_diff(r_reg, entry[23:16]);
    assign d_g      = abs_diff(g_reg, entry[15:8]);
    assign d_b      = abs_diff(b_reg, entry[7:0]);
    assign dist_sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);

    always_comb
    begin
        unique case (fmt_reg)
            FMT_332: packed_word = {16'd0, blue_in[1:0], green_in[2:0], red_in[2:0]};
            FMT_555: packed_word = {9'd0, red_in[4:0], green_in[4:0], blue_in[4:0]};
            FMT_565: packed_word = {8'd0, red_in[4:0], green_in[5:0], blue_in[4:0]};
            FMT_888: packed_word = {red_in, green_in, blue_in};
            default: packed_word = 24'd0;
        endcase
    end

    assign status.is_index  = (fmt_reg == FMT_INDEX);
    assign status.addr_last = (addr_reg == '0);
    assign status.pipe_busy = s1_vld_reg || s2_vld_reg;

    assign done       = done_reg;
    assign pixel_word = pixel_word_reg;

    `RGBPM_ASSERT(a_pipe_order, clk, rst_n, s2_vld_reg |-> $past(s1_vld_reg), "distance stage without a read")
    `RGBPM_NEVER(a_best_limit, clk, rst_n, s2_vld_reg && (best_reg > NO_MATCH_LIMIT), "best distance above limit")
    `RGBPM_NEVER(a_no_write_in_scan, clk, rst_n, ram_we && status.pipe_busy, "palette written during a search")

endmodule

`default_nettype wire

/* sv/rgb_pack_palette_match.sv */
// ----------------------------------------------------------------------------
// rgb_pack_palette_match
// Packs RGB components into a pixel word or finds the nearest palette entry.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A palette load gives
// no result. A conversion in a packed format gives its result in the cycle
// after acceptance, with busy staying low, so items can follow every cycle.
// In palette index format the block scans the palette memory one entry per
// cycle through its single read port, from the top entry down, and stays busy
// until the scan and its compare pipeline have drained; the result follows
// in the next cycle. Each result is marked by done for exactly one cycle on
// pixel_word, and the receiver cannot stall it. The format register is written
// over the cfg channel while the block is idle.
`default_nettype none

module rgb_pack_palette_match
    import rgbpm_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic             func,
    input  wire logic [7:0]       entry_index,
    input  wire logic [7:0]       red_in,
    input  wire logic [7:0]       green_in,
    input  wire logic [7:0]       blue_in,
    output logic                  done,
    output logic [23:0]           pixel_word,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [FMT_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = !busy;

    rgbpm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    rgbpm_dp #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .entry_index (entry_index),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .done        (done),
        .pixel_word  (pixel_word)
    );

endmodule

`default_nettype wire
